// ===== hw/rtl/tscrc_pkg.sv =====
// Shared constants and types for the telemetry sentence CRC appender.
package tscrc_pkg;

    // CRC-16/CCITT, MSB first
    localparam int          CRC_W        = 16;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] SEED_RESET   = 16'hFFFF;

    localparam int          CHAR_W       = 8;
    localparam int          SKIP_W       = 2;
    localparam logic [1:0]  SKIP_RESET   = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 2;
    localparam logic [1:0]  REG_CRC_SEED    = 2'd0;
    localparam logic [1:0]  REG_HEADER_SKIP = 2'd1;

    // Trailer characters
    localparam logic [7:0]  CH_STAR      = 8'h2A;
    localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_ALPHA_OFS = 8'h37;   // 'A' - 10

    // Trailer sequencer codes, counting down to idle
    localparam int          TR_W       = 3;
    localparam logic [2:0]  TR_IDLE    = 3'd0;
    localparam logic [2:0]  TR_NEWLINE = 3'd1;
    localparam logic [2:0]  TR_HEX0    = 3'd2;
    localparam logic [2:0]  TR_HEX1    = 3'd3;
    localparam logic [2:0]  TR_HEX2    = 3'd4;
    localparam logic [2:0]  TR_HEX3    = 3'd5;
    localparam logic [2:0]  TR_STAR    = 3'd6;

    // One character handed to the CRC state
    typedef struct packed {
        logic take;   // a character is processed this cycle
        logic last;   // it closes the sentence
    } step_t;

endpackage

// ===== hw/rtl/tscrc_state.sv =====
// Configuration registers, header position and running CRC of the sentence.
module tscrc_state (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr,
    input  logic [tscrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tscrc_pkg::CRC_W-1:0]       cfg_data,
    input  tscrc_pkg::step_t                  step,
    input  logic [tscrc_pkg::CHAR_W-1:0]      step_char,
    output logic [tscrc_pkg::CRC_W-1:0]       crc_after
);

    logic [tscrc_pkg::CRC_W-1:0]  seed_reg,  seed_next;
    logic [tscrc_pkg::SKIP_W-1:0] skip_reg,  skip_next;
    logic [tscrc_pkg::CRC_W-1:0]  crc_reg,   crc_next;
    logic [tscrc_pkg::SKIP_W-1:0] pos_reg,   pos_next;
    logic                         in_header;
    logic [tscrc_pkg::CRC_W-1:0]  crc_folded;

    // Byte-wide CRC update, eight shift steps unrolled
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] ch);
        logic [15:0] r;
        r = crc ^ {ch, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ tscrc_pkg::CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    assign in_header  = pos_reg < skip_reg;
    assign crc_folded = crc_fold(crc_reg, step_char);
    assign crc_after  = in_header ? crc_reg : crc_folded;

    // Next state: character step, sentence restart, register writes
    always_comb begin
        seed_next = seed_reg;
        skip_next = skip_reg;
        crc_next  = crc_reg;
        pos_next  = pos_reg;
        if (step.take) begin
            if (step.last) begin
                crc_next = seed_reg;
                pos_next = '0;
            end else if (in_header) begin
                pos_next = pos_reg + 1'b1;
            end else begin
                crc_next = crc_folded;
            end
        end
        if (cfg_wr) begin
            case (cfg_index)
                tscrc_pkg::REG_CRC_SEED: begin
                    seed_next = cfg_data;
                    crc_next  = cfg_data;
                end
                tscrc_pkg::REG_HEADER_SKIP: begin
                    skip_next = cfg_data[tscrc_pkg::SKIP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= tscrc_pkg::SEED_RESET;
            skip_reg <= tscrc_pkg::SKIP_RESET;
            crc_reg  <= tscrc_pkg::SEED_RESET;
            pos_reg  <= '0;
        end else begin
            seed_reg <= seed_next;
            skip_reg <= skip_next;
            crc_reg  <= crc_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ===== hw/rtl/telemetry_sentence_crc_appender_top.sv =====
// Top level: sentence pass-through with CRC-16 trailer ('*', four hex digits, newline).
//
// One character word is taken per clock while s_tready is high and leaves
// through the input register and then the output register; the CRC of
// everything after the header characters is updated as each character moves
// from the input register to the output register. A sentence-end word is
// followed by six trailer words, during which the input register holds the next
// character and takes no further one. The single output register sets
// the rate: one word per cycle whenever the sink is ready. No clearing pass is
// needed after reset. The configuration port is always ready and is to be
// written only while no word is held inside the block; a seed write also
// restarts the CRC of the sentence under way.
module telemetry_sentence_crc_appender_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input characters
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,    // [7:0] sentence_char
    input  logic                              s_tlast,    // sentence_end
    // output characters
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,    // [7:0] out_char
    output logic                              m_tlast,    // frame_last
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tscrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tscrc_pkg::CRC_W-1:0]       cfg_data
);

    logic                          in_valid_reg,  in_valid_next;
    logic [tscrc_pkg::CHAR_W-1:0]  in_char_reg;
    logic                          in_last_reg;
    logic [tscrc_pkg::TR_W-1:0]    trail_cnt_reg, trail_cnt_next;
    logic [tscrc_pkg::CRC_W-1:0]   trail_crc_reg;
    logic                          m_tvalid_reg,  m_tvalid_next;
    logic [tscrc_pkg::CHAR_W-1:0]  m_tdata_reg,   m_tdata_next;
    logic                          m_tlast_reg,   m_tlast_next;

    logic                          s_take;
    logic                          out_free;
    logic                          trail_active;
    logic                          in_pop;
    logic                          trail_emit;
    logic [tscrc_pkg::CRC_W-1:0]   crc_after;
    logic [3:0]                    nib;
    logic [tscrc_pkg::CHAR_W-1:0]  trail_char;
    tscrc_pkg::step_t              step;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10) begin
            return tscrc_pkg::CH_ZERO + {4'h0, n};
        end else begin
            return tscrc_pkg::CH_ALPHA_OFS + {4'h0, n};
        end
    endfunction

    // Handshake control
    assign out_free     = !m_tvalid_reg || m_tready;
    assign trail_active = trail_cnt_reg != tscrc_pkg::TR_IDLE;
    assign in_pop       = in_valid_reg && !trail_active && out_free;
    assign trail_emit   = trail_active && out_free;
    assign s_tready     = !in_valid_reg || in_pop;
    assign s_take       = s_tvalid && s_tready;
    assign cfg_ready    = 1'b1;

    assign step.take = in_pop;
    assign step.last = in_last_reg;

    tscrc_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .step_char (in_char_reg),
        .crc_after (crc_after)
    );

    // Trailer character select
    always_comb begin
        nib        = trail_crc_reg[3:0];
        trail_char = tscrc_pkg::CH_STAR;
        case (trail_cnt_reg)
            tscrc_pkg::TR_STAR:    trail_char = tscrc_pkg::CH_STAR;
            tscrc_pkg::TR_HEX3: begin
                nib        = trail_crc_reg[15:12];
                trail_char = hex_digit(nib);
            end
            tscrc_pkg::TR_HEX2: begin
                nib        = trail_crc_reg[11:8];
                trail_char = hex_digit(nib);
            end
            tscrc_pkg::TR_HEX1: begin
                nib        = trail_crc_reg[7:4];
                trail_char = hex_digit(nib);
            end
            tscrc_pkg::TR_HEX0: begin
                nib        = trail_crc_reg[3:0];
                trail_char = hex_digit(nib);
            end
            tscrc_pkg::TR_NEWLINE: trail_char = tscrc_pkg::CH_NEWLINE;
            default:               trail_char = tscrc_pkg::CH_STAR;
        endcase
    end

    // Next state of input register, trailer counter and output register
    always_comb begin
        in_valid_next  = in_valid_reg;
        trail_cnt_next = trail_cnt_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        if (in_pop) begin
            in_valid_next = 1'b0;
        end
        if (s_take) begin
            in_valid_next = 1'b1;
        end
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (in_pop) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = in_char_reg;
            m_tlast_next  = 1'b0;
            if (in_last_reg) begin
                trail_cnt_next = tscrc_pkg::TR_STAR;
            end
        end else if (trail_emit) begin
            m_tvalid_next  = 1'b1;
            m_tdata_next   = trail_char;
            m_tlast_next   = trail_cnt_reg == tscrc_pkg::TR_NEWLINE;
            trail_cnt_next = trail_cnt_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            trail_cnt_reg <= tscrc_pkg::TR_IDLE;
            m_tvalid_reg  <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            trail_cnt_reg <= trail_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_pop && in_last_reg) begin
            trail_crc_reg <= crc_after;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // No input character leaves while a trailer is being sent
    a_no_pop_in_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        trail_active |-> !in_pop) else $error("character popped during trailer");

    // A sentence end starts the trailer with the star
    a_trailer_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_pop && in_last_reg |=> trail_cnt_reg == tscrc_pkg::TR_STAR)
        else $error("trailer not started after sentence end");

    // The newline step presents a frame end
    a_newline_last: assert property (@(posedge aclk) disable iff (!aresetn)
        trail_emit && trail_cnt_reg == tscrc_pkg::TR_NEWLINE |=>
        m_tvalid && m_tlast && m_tdata == tscrc_pkg::CH_NEWLINE)
        else $error("newline word missing frame end");

    // Frame end is only ever on a newline
    a_last_is_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == tscrc_pkg::CH_NEWLINE)
        else $error("frame end on a non-newline word");

endmodule

// ===== bench/tb_telemetry_sentence_crc_appender_top.sv =====
// Self-checking bench for the telemetry sentence CRC appender: directed and random sentences.
`timescale 1ns / 100ps

module tb_telemetry_sentence_crc_appender_top;
    import tscrc_pkg::*;

    // spare register indexes, writes to them must change nothing
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         RANDOM_WORDS = 195;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] sentence_char
    logic        s_tlast;    // sentence_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;    // [7:0] out_char
    logic        m_tlast;    // frame_last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CRC_W-1:0]     cfg_data;

    // predictor state, mirrors the block's registers
    logic [15:0] seed_reg;
    logic [1:0]  skip_reg;
    logic [15:0] sentence_crc;
    logic [1:0]  header_count;

    char_word_t  pending_chars[$];
    int          err_count = 0;
    int          quiet_cycles = 0;
    int          words_sent = 0;
    bit          src_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int          stall_left = 0;

    telemetry_sentence_crc_appender_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // CRC-16/CCITT, one character folded in MSB first
    function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] ch);
        logic [15:0] r;
        r = crc ^ {ch, 8'h00};
        for (int b = 0; b < 8; b++)
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        return (nib < 4'd10) ? (CH_ZERO + 8'(nib)) : (CH_ALPHA_OFS + 8'(nib));
    endfunction

    function automatic void expect_char(logic [7:0] ch, logic last);
        char_word_t w;
        w.ch   = ch;
        w.last = last;
        pending_chars.push_back(w);
    endfunction

    // expected output words for one accepted input character
    function automatic void predict_char(logic [7:0] ch, logic eos);
        logic [15:0] c;
        expect_char(ch, 1'b0);
        if (header_count < skip_reg) begin
            header_count = header_count + 2'd1;
        end else begin
            sentence_crc = crc16_fold(sentence_crc, ch);
        end
        if (eos) begin
            c = sentence_crc;
            expect_char(CH_STAR, 1'b0);
            expect_char(hex_char(c[15:12]), 1'b0);
            expect_char(hex_char(c[11:8]), 1'b0);
            expect_char(hex_char(c[7:4]), 1'b0);
            expect_char(hex_char(c[3:0]), 1'b0);
            expect_char(CH_NEWLINE, 1'b1);
            sentence_crc = seed_reg;
            header_count = 2'd0;
        end
    endfunction

    function automatic void check_char(logic [7:0] ch, logic last);
        char_word_t w;
        if (pending_chars.size() == 0) begin
            if (err_count < 10)
                $display("%0t: unexpected output word char=%02h last=%b", $realtime, ch, last);
            err_count++;
            return;
        end
        w = pending_chars.pop_front();
        if (w.ch !== ch || w.last !== last) begin
            if (err_count < 10)
                $display("%0t: mismatch char exp=%02h got=%02h, last exp=%b got=%b",
                         $realtime, w.ch, ch, w.last, last);
            err_count++;
        end
    endfunction

    // input prediction, output check and activity count, all on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles = 0;
        end else begin
            if (s_tvalid && s_tready) predict_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) check_char(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // sink back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sink_stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    // watchdog on a stuck handshake
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // enters and leaves at a falling edge; valid stays high when no gap follows
    task automatic send_char(input logic [7:0] ch, input logic eos);
        int gap;
        s_tdata  <= ch;
        s_tlast  <= eos;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        @(negedge aclk);
        gap = src_gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_string(input string txt, input logic close);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], close && (i == txt.len() - 1));
    endtask

    // stop sending and let every expected word come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        wait_drained();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_CRC_SEED) begin
            seed_reg     = val;
            sentence_crc = val;
        end else if (idx == REG_HEADER_SKIP) begin
            skip_reg = val[1:0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // default registers, zero and all-ones characters
    task automatic test_reset_defaults();
        send_char("$", 1'b0);
        send_char("$", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    // header skip at both extremes, upper data bits set for the zero value
    task automatic test_skip_extremes();
        write_reg(REG_HEADER_SKIP, 16'hFFFC);
        send_char("A", 1'b1);
        write_reg(REG_HEADER_SKIP, 16'h0003);
        send_string("$$$X", 1'b1);
    endtask

    // seed at zero and all ones
    task automatic test_seed_extremes();
        write_reg(REG_HEADER_SKIP, 16'h0000);
        write_reg(REG_CRC_SEED, 16'h0000);
        send_string("OK", 1'b1);
        write_reg(REG_CRC_SEED, 16'hFFFF);
        write_reg(REG_HEADER_SKIP, 16'h0002);
    endtask

    // sentence closed while still inside the header: trailer carries the seed
    task automatic test_end_in_header();
        write_reg(REG_HEADER_SKIP, 16'h0003);
        send_string("$$", 1'b1);
        write_reg(REG_HEADER_SKIP, 16'h0002);
        send_char("$", 1'b1);
    endtask

    // register writes in the middle of a sentence
    task automatic test_mid_sentence_writes();
        send_char("$", 1'b0);
        write_reg(REG_HEADER_SKIP, 16'h0003);
        send_string("ab", 1'b0);
        write_reg(REG_CRC_SEED, 16'h1234);
        send_char("c", 1'b0);
        write_reg(REG_HEADER_SKIP, 16'h0000);
        send_char("d", 1'b1);
    endtask

    // spare indexes leave both registers alone
    task automatic test_spare_index();
        write_reg(REG_SPARE_LO, 16'hA5A5);
        write_reg(REG_SPARE_HI, 16'h5A5A);
        send_string("$$Z", 1'b1);
    endtask

    task automatic random_reg_write();
        case ($urandom_range(0, 5))
            0: write_reg(REG_CRC_SEED, 16'($urandom()));
            1: write_reg(REG_CRC_SEED, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            2, 3: write_reg(REG_HEADER_SKIP, 16'($urandom()));
            4: write_reg(REG_HEADER_SKIP, 16'(SKIP_RESET));
            default: write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                               16'($urandom()));
        endcase
    endtask

    // random sentences back to back, occasional register changes between them
    task automatic test_random_sentences();
        int len;
        int target;
        logic [7:0] ch;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            if ($urandom_range(0, 5) == 0) random_reg_write();
            src_gaps_on    = ($urandom_range(0, 9) < 7);
            sink_stalls_on = ($urandom_range(0, 9) < 7);
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 14);
            for (int i = 0; i < len; i++) begin
                if (i < 2 && $urandom_range(0, 1)) ch = "$";
                else if ($urandom_range(0, 4) == 0) ch = 8'($urandom());
                else ch = 8'($urandom_range(8'h20, 8'h7E));
                send_char(ch, i == len - 1);
            end
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_CRC_SEED;
        cfg_data     = 16'h0000;
        seed_reg     = SEED_RESET;
        skip_reg     = SKIP_RESET;
        sentence_crc = SEED_RESET;
        header_count = 2'd0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_skip_extremes();
        test_seed_extremes();
        test_end_in_header();
        test_mid_sentence_writes();
        test_spare_index();
        test_random_sentences();

        wait_drained();
        repeat (8) @(negedge aclk);
        if (pending_chars.size() != 0) err_count++;
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== telemetry_sentence_crc_appender_top.f =====
hw/rtl/tscrc_pkg.sv
hw/rtl/tscrc_state.sv
hw/rtl/telemetry_sentence_crc_appender_top.sv
bench/tb_telemetry_sentence_crc_appender_top.sv
